[src/b64l_pkg.sv]
package b64l_pkg;

   localparam int BYTES_PER_LINE = 54;
   localparam int LINE_CNT_W     = (BYTES_PER_LINE > 1) ? $clog2(BYTES_PER_LINE) : 1;
   localparam int MAX_CHARS      = 5;
   localparam int CHAR_CNT_W     = $clog2(MAX_CHARS + 1);

   localparam logic [7:0] CHAR_NEWLINE = 8'h0A;
   localparam logic [7:0] CHAR_PAD     = 8'h3D;

   typedef struct packed {
      logic [MAX_CHARS-1:0][7:0] chars;   // chars[0] goes out first
      logic [CHAR_CNT_W-1:0]     count;
   } burst_type;

   // standard alphabet: A-Z, a-z, 0-9, '+', '/'
   function automatic logic [7:0] b64_char(input logic [5:0] v);
      logic [7:0] x;
      x = {2'b00, v};
      if (v < 6'd26)
         b64_char = 8'h41 + x;
      else if (v < 6'd52)
         b64_char = 8'h61 + x - 8'd26;
      else if (v < 6'd62)
         b64_char = 8'h30 + x - 8'd52;
      else if (v == 6'd62)
         b64_char = 8'h2B;
      else
         b64_char = 8'h2F;
   endfunction

endpackage

[src/base64_line_wrapped_encoder.sv]
// The first char of a byte's encoding is valid the cycle after its transfer.
// One char leaves per cycle while rsp_stall is low; a byte causes 0, 1, 4 or 5 chars,
// and req_stall holds the next byte until all but the last of them are out. A line
// break rides on the byte that opens the group and adds a newline char to its burst.
// The next byte is taken in the same cycle as the last char of the previous one.
// Reset (synchronous) clears the group, line count and pending chars.
module base64_line_wrapped_encoder (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic [7:0] req_data_byte,
   input  logic       req_final_byte,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_out_char,
   output logic       rsp_end_of_run
);

   b64l_pkg::burst_type burst;
   logic                accept;
   logic                busy;

   assign req_stall = busy;
   assign accept    = req_valid && !busy;

   b64l_core u_core (
      .clock      (clock),
      .reset      (reset),
      .accept     (accept),
      .data_byte  (req_data_byte),
      .final_byte (req_final_byte),
      .burst      (burst)
   );

   b64l_emit u_emit (
      .clock          (clock),
      .reset          (reset),
      .load           (accept),
      .burst          (burst),
      .busy           (busy),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_out_char   (rsp_out_char),
      .rsp_end_of_run (rsp_end_of_run)
   );

endmodule

[src/b64l_core.sv]
module b64l_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          data_byte,
   input  logic                final_byte,
   output b64l_pkg::burst_type burst
);

   logic [15:0]                     held_ff, held_in;
   logic [1:0]                      pos_ff, pos_in;
   logic [b64l_pkg::LINE_CNT_W-1:0] line_ff, line_in;
   logic                            started_ff, started_in;

   logic [1:0]  pos;
   logic        newline;
   logic        close;
   logic [15:0] held_next;
   logic [23:0] bits;
   logic [7:0]  c0, c1, c2, c3;

   always_comb begin
      pos     = (pos_ff == 2'd3) ? 2'd2 : pos_ff;
      newline = (pos == 2'd0) && started_ff && (line_ff == '0);
      close   = final_byte || (pos == 2'd2);

      case (pos)
         2'd0:    held_next = {data_byte, 8'h00};
         2'd1:    held_next = {held_ff[15:8], data_byte};
         default: held_next = held_ff;
      endcase

      bits = {held_next, (pos == 2'd2) ? data_byte : 8'h00};
      c0   = b64l_pkg::b64_char(bits[23:18]);
      c1   = b64l_pkg::b64_char(bits[17:12]);
      c2   = (pos != 2'd0) ? b64l_pkg::b64_char(bits[11:6]) : b64l_pkg::CHAR_PAD;
      c3   = (pos == 2'd2) ? b64l_pkg::b64_char(bits[5:0]) : b64l_pkg::CHAR_PAD;

      burst.chars = '0;
      if (newline) begin
         burst.chars[0] = b64l_pkg::CHAR_NEWLINE;
         burst.chars[1] = c0;
         burst.chars[2] = c1;
         burst.chars[3] = c2;
         burst.chars[4] = c3;
      end else begin
         burst.chars[0] = c0;
         burst.chars[1] = c1;
         burst.chars[2] = c2;
         burst.chars[3] = c3;
      end

      if (close)
         burst.count = newline ? b64l_pkg::CHAR_CNT_W'(5) : b64l_pkg::CHAR_CNT_W'(4);
      else
         burst.count = newline ? b64l_pkg::CHAR_CNT_W'(1) : b64l_pkg::CHAR_CNT_W'(0);

      held_in    = held_ff;
      pos_in     = pos_ff;
      line_in    = line_ff;
      started_in = started_ff;
      if (accept) begin
         if (final_byte) begin
            held_in    = '0;
            pos_in     = '0;
            line_in    = '0;
            started_in = 1'b0;
         end else begin
            held_in    = close ? 16'h0000 : held_next;
            pos_in     = close ? 2'd0 : pos + 2'd1;
            line_in    = (line_ff == b64l_pkg::LINE_CNT_W'(b64l_pkg::BYTES_PER_LINE - 1))
                         ? '0 : line_ff + 1'b1;
            started_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         held_ff    <= '0;
         pos_ff     <= '0;
         line_ff    <= '0;
         started_ff <= 1'b0;
      end else begin
         held_ff    <= held_in;
         pos_ff     <= pos_in;
         line_ff    <= line_in;
         started_ff <= started_in;
      end
   end

   a_final_clears: assert property (@(posedge clock) disable iff (reset)
      (accept && final_byte) |=> (pos_ff == 2'd0 && line_ff == '0 && !started_ff))
      else $error("state not cleared after final byte");

   a_pos_range: assert property (@(posedge clock) disable iff (reset)
      pos_ff != 2'd3)
      else $error("group position out of range");

   a_line_range: assert property (@(posedge clock) disable iff (reset)
      line_ff <= b64l_pkg::LINE_CNT_W'(b64l_pkg::BYTES_PER_LINE - 1))
      else $error("line count out of range");

endmodule

[src/b64l_emit.sv]
module b64l_emit (
   input  logic                clock,
   input  logic                reset,
   input  logic                load,
   input  b64l_pkg::burst_type burst,
   output logic                busy,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [7:0]          rsp_out_char,
   output logic                rsp_end_of_run
);

   logic [b64l_pkg::MAX_CHARS-1:0][7:0] chars_ff, chars_in;
   logic [b64l_pkg::CHAR_CNT_W-1:0]     count_ff, count_in;
   logic                                take;

   assign rsp_valid      = (count_ff != '0);
   assign rsp_out_char   = chars_ff[0];
   assign rsp_end_of_run = (count_ff == b64l_pkg::CHAR_CNT_W'(1));
   assign take           = rsp_valid && !rsp_stall;
   // free (a load may be taken now) if empty or the last char leaves now
   assign busy           = (count_ff > b64l_pkg::CHAR_CNT_W'(1)) || (rsp_valid && rsp_stall);

   always_comb begin
      chars_in = chars_ff;
      count_in = count_ff;
      if (load) begin
         chars_in = burst.chars;
         count_in = burst.count;
      end else if (take) begin
         for (int i = 0; i < b64l_pkg::MAX_CHARS - 1; i++)
            chars_in[i] = chars_ff[i+1];
         chars_in[b64l_pkg::MAX_CHARS-1] = 8'h00;
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else begin
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      chars_ff <= chars_in;
   end

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= b64l_pkg::CHAR_CNT_W'(b64l_pkg::MAX_CHARS))
      else $error("burst count out of range");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      load |-> (count_ff == '0 || (count_ff == b64l_pkg::CHAR_CNT_W'(1) && take)))
      else $error("burst loaded over pending chars");

endmodule
